>>> sv/ftsr_pkg.sv
// ----------------------------------------------------------------------------
// ftsr_pkg
// shared widths, register codes, reset values and bundles of the frame time
// step regulator
// ----------------------------------------------------------------------------
package ftsr_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int TV_BITS       = 48;
    localparam int NOW_BITS      = 48;
    localparam int STEP_BITS     = 32;
    localparam int REG_BITS      = 21;
    localparam int MODE_BITS     = 3;
    localparam int CFG_IDX_BITS  = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_NONE           = 3'd0,
        MODE_CONST_OR_ABOVE = 3'd1,
        MODE_CONST_OR_BELOW = 3'd2,
        MODE_BELOW          = 3'd3,
        MODE_CONSTANT       = 3'd4,
        MODE_FIRST_ORDER    = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE          = 3'd0,
        CFG_CONST_STEP    = 3'd1,
        CFG_MAX_STEP      = 3'd2,
        CFG_MIN_STEP      = 3'd3,
        CFG_SLEW_STEP     = 3'd4,
        CFG_MAX_SMOOTHED  = 3'd5
    } cfg_idx_t;

    localparam logic [REG_BITS-1:0] CONST_STEP_RST   = 21'd33333;
    localparam logic [REG_BITS-1:0] MAX_STEP_RST     = 21'd990000;
    localparam logic [REG_BITS-1:0] MIN_STEP_RST     = 21'd16667;
    localparam logic [REG_BITS-1:0] SLEW_STEP_RST    = 21'd6667;
    localparam logic [REG_BITS-1:0] MAX_SMOOTHED_RST = 21'd100000;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [REG_BITS-1:0]  const_step;
        logic [REG_BITS-1:0]  max_step;
        logic [REG_BITS-1:0]  min_step;
        logic [REG_BITS-1:0]  slew_step;
        logic [REG_BITS-1:0]  max_smoothed_step;
    } cfg_t;

    typedef struct packed {
        logic signed [STEP_BITS-1:0] step;
        logic                        skipped;
        logic [NOW_BITS-1:0]         now_time;
    } res_t;

endpackage

>>> sv/ftsr_if.sv
// ----------------------------------------------------------------------------
// ftsr_in_if / ftsr_out_if
// valid/ready channels carrying frame time words and step result words
// ----------------------------------------------------------------------------
interface ftsr_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [ftsr_pkg::TV_BITS-1:0]    time_value;
    logic                            paused;

    modport source (output valid, kind, time_value, paused, input ready);
    modport sink   (input valid, kind, time_value, paused, output ready);
endinterface

interface ftsr_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ftsr_pkg::STEP_BITS-1:0]  step;
    logic                                   skipped;
    logic [ftsr_pkg::NOW_BITS-1:0]          now_time;

    modport source (output valid, step, skipped, now_time, input ready);
    modport sink   (input valid, step, skipped, now_time, output ready);
endinterface

>>> sv/ftsr_cfg.sv
// ----------------------------------------------------------------------------
// ftsr_cfg
// configuration register file, write only, values masked to register width
// ----------------------------------------------------------------------------
module ftsr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ftsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ftsr_pkg::REG_BITS-1:0]       cfg_data,
    output ftsr_pkg::cfg_t                      cfg
);

    ftsr_pkg::cfg_t cfg_reg;
    ftsr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ftsr_pkg::CFG_MODE:
                    cfg_next.mode = cfg_data[ftsr_pkg::MODE_BITS-1:0];
                ftsr_pkg::CFG_CONST_STEP:   cfg_next.const_step        = cfg_data;
                ftsr_pkg::CFG_MAX_STEP:     cfg_next.max_step          = cfg_data;
                ftsr_pkg::CFG_MIN_STEP:     cfg_next.min_step          = cfg_data;
                ftsr_pkg::CFG_SLEW_STEP:    cfg_next.slew_step         = cfg_data;
                ftsr_pkg::CFG_MAX_SMOOTHED: cfg_next.max_smoothed_step = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode              <= ftsr_pkg::MODE_CONSTANT;
            cfg_reg.const_step        <= ftsr_pkg::CONST_STEP_RST;
            cfg_reg.max_step          <= ftsr_pkg::MAX_STEP_RST;
            cfg_reg.min_step          <= ftsr_pkg::MIN_STEP_RST;
            cfg_reg.slew_step         <= ftsr_pkg::SLEW_STEP_RST;
            cfg_reg.max_smoothed_step <= ftsr_pkg::MAX_SMOOTHED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/ftsr_step.sv
// ----------------------------------------------------------------------------
// ftsr_step
// frame time state and the combinational step rule for one registered word
// ----------------------------------------------------------------------------
module ftsr_step #(
    parameter int TIME_BITS = ftsr_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  logic                             kind,
    input  logic [ftsr_pkg::TV_BITS-1:0]     time_value,
    input  logic                             paused,
    input  ftsr_pkg::cfg_t                   cfg,
    output ftsr_pkg::res_t                   res,
    output logic [TIME_BITS-1:0]             cur_time
);

    // signed working width, holds any time difference exactly
    localparam int W  = TIME_BITS + 3;
    // width of an addend for the saturating add
    localparam int AD = (TIME_BITS > ftsr_pkg::TV_BITS) ? TIME_BITS : ftsr_pkg::TV_BITS;
    localparam bit LIM_ON = (TIME_BITS > 62);
    localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};
    localparam logic signed [W-1:0] DIFF_LIM = W'(64'sd1 <<< 62);
    localparam logic signed [W-1:0] S32_MAX  = W'(32'sh7FFF_FFFF);
    localparam logic signed [W-1:0] S32_MIN  = W'(32'sh8000_0000);

    function automatic logic [TIME_BITS-1:0] add_sat(
        input logic [TIME_BITS-1:0] t,
        input logic [AD-1:0]        d
    );
        logic [AD:0] s;
        s = (AD+1)'(t) + (AD+1)'(d);
        return (s > (AD+1)'(TIME_MASK)) ? TIME_MASK : TIME_BITS'(s);
    endfunction

    // time moved by a signed amount, stops at zero and at the top
    function automatic logic [TIME_BITS-1:0] move_sat(
        input logic [TIME_BITS-1:0] t,
        input logic signed [W-1:0]  d
    );
        logic signed [W:0] m;
        m = $signed({4'b0000, t}) + (W+1)'(d);
        if (m < 0)
            return '0;
        else if (m > $signed((W+1)'(TIME_MASK)))
            return TIME_MASK;
        else
            return TIME_BITS'(m);
    endfunction

    function automatic logic signed [W-1:0] diff_time(
        input logic [TIME_BITS-1:0] a,
        input logic [TIME_BITS-1:0] b
    );
        logic signed [W-1:0] d;
        d = $signed({3'b000, a}) - $signed({3'b000, b});
        if (LIM_ON && (d > DIFF_LIM))
            d = DIFF_LIM;
        else if (LIM_ON && (d < -DIFF_LIM))
            d = -DIFF_LIM;
        return d;
    endfunction

    function automatic logic signed [W-1:0] ext_reg(
        input logic [ftsr_pkg::REG_BITS-1:0] v
    );
        return $signed(W'(v));
    endfunction

    function automatic logic signed [ftsr_pkg::STEP_BITS-1:0] sat32(
        input logic signed [W-1:0] v
    );
        logic signed [W-1:0] c;
        c = v;
        if (v > S32_MAX)
            c = S32_MAX;
        else if (v < S32_MIN)
            c = S32_MIN;
        return ftsr_pkg::STEP_BITS'(c);
    endfunction

    logic [TIME_BITS-1:0] cur_reg, lft_reg, nft_reg;
    logic [TIME_BITS-1:0] cur_next, lft_next, nft_next;
    logic signed [ftsr_pkg::STEP_BITS-1:0] ls_reg, ls_next;

    logic [TIME_BITS-1:0]  t_val, cur_n, na, nb, mv, mv_hi, mv_lo;
    logic                  stale, skip;
    logic signed [W-1:0]   e, e_mx, step, cs_s, mx_s, sl_s, mss_s, mn_s, ls_s;
    logic signed [W-1:0]   s_hi, s_lo, s;

    always_comb
    begin
        // arriving time, absolute or relative to the last frame
        if (kind)
            t_val = add_sat(lft_reg, AD'(time_value));
        else if (AD'(time_value) > AD'(TIME_MASK))
            t_val = TIME_MASK;
        else
            t_val = TIME_BITS'(time_value);

        stale = !paused && (cur_reg >= t_val);
        cur_n = paused ? cur_reg : t_val;
        e     = diff_time(cur_n, lft_reg);

        cs_s  = ext_reg(cfg.const_step);
        mx_s  = ext_reg(cfg.max_step);
        sl_s  = ext_reg(cfg.slew_step);
        mss_s = ext_reg(cfg.max_smoothed_step);
        mn_s  = ext_reg(cfg.min_step);
        ls_s  = W'(ls_reg);

        na   = add_sat(nft_reg, AD'(cfg.const_step));
        nb   = add_sat(cur_n, AD'(cfg.const_step));
        e_mx = (e > mx_s) ? mx_s : e;

        // slew-limited follower: e clamped to last step +- slew,
        // both clamped frame moves ready ahead of e
        s_hi  = ls_s + sl_s;
        s_lo  = ls_s - sl_s;
        mv_hi = move_sat(lft_reg, s_hi);
        mv_lo = move_sat(lft_reg, s_lo);
        if (e > s_hi)
        begin
            s  = s_hi;
            mv = mv_hi;
        end
        else if (e < s_lo)
        begin
            s  = s_lo;
            mv = mv_lo;
        end
        else
        begin
            // moving the last frame by e lands on the current time
            s  = e;
            mv = cur_n;
        end

        step     = '0;
        skip     = 1'b0;
        cur_next = cur_n;
        lft_next = lft_reg;
        nft_next = nft_reg;
        ls_next  = ls_reg;

        case (cfg.mode)
            ftsr_pkg::MODE_NONE:
            begin
                step     = e_mx;
                lft_next = cur_n;
                ls_next  = sat32(e);
            end
            ftsr_pkg::MODE_CONST_OR_ABOVE:
            begin
                step     = (e > cs_s) ? cs_s : e;
                lft_next = cur_n;
                ls_next  = sat32((e > cs_s) ? cs_s : e);
            end
            ftsr_pkg::MODE_CONST_OR_BELOW:
            begin
                if (e <= 0)
                    step = '0;
                else if (e >= cs_s)
                begin
                    if (e < diff_time(na, lft_reg))
                    begin
                        step     = cs_s;
                        nft_next = na;
                        lft_next = na;
                    end
                    else
                    begin
                        step     = e_mx;
                        nft_next = nb;
                        lft_next = nb;
                    end
                end
                else
                begin
                    step     = cs_s;
                    nft_next = na;
                    lft_next = na;
                end
            end
            ftsr_pkg::MODE_BELOW:
            begin
                if (lft_reg <= nft_reg)
                begin
                    if (cur_n > nft_reg)
                    begin
                        nft_next = (cur_n >= na) ? cur_n : na;
                        lft_next = cur_n;
                        step     = e_mx;
                    end
                end
                else
                begin
                    nft_next = nb;
                    lft_next = cur_n;
                    step     = e_mx;
                end
            end
            ftsr_pkg::MODE_CONSTANT:
            begin
                // gaps up to the minimum are skipped
                if (mn_s >= e)
                    skip = 1'b1;
                else
                begin
                    step     = cs_s;
                    lft_next = cur_n;
                    ls_next  = sat32(cs_s);
                end
            end
            ftsr_pkg::MODE_FIRST_ORDER:
            begin
                if (s > mss_s)
                begin
                    step     = e;
                    ls_next  = sat32(cs_s);
                    lft_next = cur_n;
                end
                else
                begin
                    step     = s;
                    lft_next = mv;
                    ls_next  = sat32(s);
                end
            end
            default:
                step = cs_s;
        endcase

        // time did not move forward: nothing changes
        if (stale)
        begin
            step     = '0;
            skip     = 1'b1;
            cur_next = cur_reg;
            lft_next = lft_reg;
            nft_next = nft_reg;
            ls_next  = ls_reg;
        end

        res.step     = sat32(step);
        res.skipped  = skip;
        res.now_time = ftsr_pkg::NOW_BITS'(cur_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            lft_reg <= '0;
            nft_reg <= '0;
            ls_reg  <= '0;
        end
        else if (fire)
        begin
            cur_reg <= cur_next;
            lft_reg <= lft_next;
            nft_reg <= nft_next;
            ls_reg  <= ls_next;
        end
    end

    assign cur_time = cur_reg;

endmodule

>>> sv/frame_time_step_regulator.sv
// ----------------------------------------------------------------------------
// frame_time_step_regulator
// grants each frame a time step from the arriving frame time
//
// item channel: one word per frame, kind (absolute or delta time),
// time_value in microseconds and a paused flag. result channel: one word per
// item, the signed step in microseconds, a skipped flag and the held current
// time. the cfg port writes mode and the step limits, one register per cycle
// at the edge where cfg_we is high; the user must make writes only while the
// block is idle, and the block itself does not enforce it. an accepted word
// sits in the input register while its step is worked out, and the result is
// registered when the step stage fires and the result register can take it.
// the block takes one word per cycle while the receiver does not stall,
// bounded by the frame state update, which closes in the step stage.
// reset clears all frame times and the stored step and loads the register
// defaults (constant mode, 33333 us interval). when the receiver stalls the
// result stays in the output register, the step stage holds one more word,
// and item.ready falls only once both are full.
// ----------------------------------------------------------------------------
module frame_time_step_regulator #(
    parameter int TIME_BITS = ftsr_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ftsr_in_if.sink                             item,
    ftsr_out_if.source                          result,
    input  logic                                cfg_we,
    input  logic [ftsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ftsr_pkg::REG_BITS-1:0]       cfg_data
);

    ftsr_pkg::cfg_t cfg;
    ftsr_pkg::res_t step_res;
    logic [TIME_BITS-1:0] cur_time;

    // input register
    logic                           in_v_reg, in_v_next;
    logic                           kind_reg;
    logic [ftsr_pkg::TV_BITS-1:0]   tv_reg;
    logic                           paused_reg;

    // result register
    logic                           out_v_reg, out_v_next;
    ftsr_pkg::res_t                 res_reg;

    logic adv;      // result register can take a new word
    logic fire;     // step stage retires its word
    logic take;     // input word accepted

    ftsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ftsr_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .kind       (kind_reg),
        .time_value (tv_reg),
        .paused     (paused_reg),
        .cfg        (cfg),
        .res        (step_res),
        .cur_time   (cur_time)
    );

    assign adv        = !out_v_reg || result.ready;
    assign fire       = in_v_reg && adv;
    assign item.ready = !in_v_reg || adv;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        in_v_next  = take ? 1'b1 : (fire ? 1'b0 : in_v_reg);
        out_v_next = fire ? 1'b1 : (result.ready ? 1'b0 : out_v_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg   <= item.kind;
            tv_reg     <= item.time_value;
            paused_reg <= item.paused;
        end
        if (fire)
            res_reg <= step_res;
    end

    assign result.valid    = out_v_reg;
    assign result.step     = res_reg.step;
    assign result.skipped  = res_reg.skipped;
    assign result.now_time = res_reg.now_time;

    // a skipped frame never grants time
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.skipped |-> result.step == '0)
        else $error("skipped result with nonzero step");

    // current time only moves forward
    a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cur_time >= $past(cur_time))
        else $error("current time moved backward");

    // a word blocked in the step stage is held
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && !adv |=> in_v_reg && $stable(tv_reg) && $stable(kind_reg))
        else $error("step stage word lost while stalled");

endmodule

>>> dv/ftsr_step_checker.sv
// ----------------------------------------------------------------------------
// ftsr_step_checker
// watches the frame word and step word channels and the register port of the
// frame time step regulator, predicts every step word from its own copy of the
// frame state and compares in order; reports a failure count to the bench
// ----------------------------------------------------------------------------
module ftsr_step_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    ftsr_in_if                                  item,
    ftsr_out_if                                 result,
    input  logic                                cfg_we,
    input  logic [ftsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ftsr_pkg::REG_BITS-1:0]       cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output longint                              held_time
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TIME_MAX = (longint'(1) << ftsr_pkg::TIME_BITS_DEF) - 1;
    localparam longint INT32_HI = longint'(32'h7fff_ffff);
    localparam longint INT32_LO = -INT32_HI - 1;
    localparam int     REPORT_MAX = 10;

    // register copy
    logic [ftsr_pkg::MODE_BITS-1:0] mode_reg;
    longint const_us, max_us, min_us, slew_us, smooth_us;

    // frame state copy
    longint now_us, frame_us, next_us;
    int     last_granted;

    ftsr_pkg::res_t step_words[$];
    int             errs;

    function automatic longint time_add(longint t, longint d);
        longint s;
        s = t + d;
        return (s > TIME_MAX) ? TIME_MAX : s;
    endfunction

    function automatic longint time_move(longint t, longint d);
        if (d >= 0)
            return time_add(t, d);
        return (-d >= t) ? 0 : t + d;
    endfunction

    function automatic int clamp32(longint v);
        if (v > INT32_HI)
            return int'(INT32_HI);
        if (v < INT32_LO)
            return int'(INT32_LO);
        return int'(v);
    endfunction

    // one frame word in, the granted step word out; updates the frame state
    function automatic ftsr_pkg::res_t grant_step(logic kind,
                                                  logic [ftsr_pkg::TV_BITS-1:0] tv,
                                                  logic paused);
        ftsr_pkg::res_t r;
        longint t, e, grant, s, gap, ls;
        logic   skip;
        grant = 0;
        skip  = 1'b0;
        t = kind ? time_add(frame_us, longint'(tv)) : longint'(tv);
        if (!paused && now_us >= t) begin
            skip = 1'b1;
        end
        else begin
            if (!paused)
                now_us = t;
            e = now_us - frame_us;
            case (mode_reg)
                ftsr_pkg::MODE_NONE: begin
                    grant        = (e > max_us) ? max_us : e;
                    frame_us     = now_us;
                    last_granted = clamp32(e);
                end
                ftsr_pkg::MODE_CONST_OR_ABOVE: begin
                    grant        = (e > const_us) ? const_us : e;
                    frame_us     = now_us;
                    last_granted = clamp32(grant);
                end
                ftsr_pkg::MODE_CONST_OR_BELOW: begin
                    if (e <= 0) begin
                        grant = 0;
                    end
                    else if (e >= const_us) begin
                        next_us = time_add(next_us, const_us);
                        if (e < next_us - frame_us) begin
                            grant    = const_us;
                            frame_us = next_us;
                        end
                        else begin
                            next_us  = time_add(now_us, const_us);
                            frame_us = next_us;
                            grant    = (e > max_us) ? max_us : e;
                        end
                    end
                    else begin
                        grant    = const_us;
                        next_us  = time_add(next_us, const_us);
                        frame_us = next_us;
                    end
                end
                ftsr_pkg::MODE_BELOW: begin
                    if (frame_us <= next_us) begin
                        if (now_us > next_us) begin
                            next_us = time_add(next_us, const_us);
                            if (now_us >= next_us)
                                next_us = now_us;
                            frame_us = now_us;
                            grant    = (e > max_us) ? max_us : e;
                        end
                    end
                    else begin
                        next_us  = time_add(now_us, const_us);
                        frame_us = now_us;
                        grant    = (e > max_us) ? max_us : e;
                    end
                end
                ftsr_pkg::MODE_CONSTANT: begin
                    if (min_us >= e) begin
                        skip = 1'b1;
                    end
                    else begin
                        grant        = const_us;
                        frame_us     = now_us;
                        last_granted = clamp32(const_us);
                    end
                end
                ftsr_pkg::MODE_FIRST_ORDER: begin
                    ls  = longint'(last_granted);
                    gap = ls - e;
                    if (gap < 0)
                        gap = -gap;
                    s = e;
                    if (gap > slew_us)
                        s = (ls < e) ? ls + slew_us : ls - slew_us;
                    if (s > smooth_us) begin
                        grant        = e;
                        last_granted = clamp32(const_us);
                        frame_us     = now_us;
                    end
                    else begin
                        grant        = s;
                        frame_us     = time_move(frame_us, s);
                        last_granted = clamp32(s);
                    end
                end
                default: grant = const_us;
            endcase
        end
        r.step     = clamp32(grant);
        r.skipped  = skip;
        r.now_time = now_us[ftsr_pkg::NOW_BITS-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        ftsr_pkg::res_t want;
        if (!rst_n) begin
            mode_reg     = ftsr_pkg::MODE_CONSTANT;
            const_us     = longint'(ftsr_pkg::CONST_STEP_RST);
            max_us       = longint'(ftsr_pkg::MAX_STEP_RST);
            min_us       = longint'(ftsr_pkg::MIN_STEP_RST);
            slew_us      = longint'(ftsr_pkg::SLEW_STEP_RST);
            smooth_us    = longint'(ftsr_pkg::MAX_SMOOTHED_RST);
            now_us       = 0;
            frame_us     = 0;
            next_us      = 0;
            last_granted = 0;
            errs         = 0;
            step_words.delete();
            fail_count  <= 0;
            pending     <= 0;
            held_time   <= 0;
        end
        else begin
            // compare before pushing so a stray word never meets its own prediction
            if (result.valid && result.ready) begin
                if (step_words.size() == 0) begin
                    errs++;
                    if (errs <= REPORT_MAX)
                        $display("unexpected step word: step %0d skipped %0b now %0d",
                                 result.step, result.skipped, result.now_time);
                end
                else begin
                    want = step_words.pop_front();
                    if (want.step !== result.step || want.skipped !== result.skipped ||
                        want.now_time !== result.now_time) begin
                        errs++;
                        if (errs <= REPORT_MAX)
                            $display({"step word mismatch: want step %0d skipped %0b ",
                                      "now %0d, got step %0d skipped %0b now %0d"},
                                     want.step, want.skipped, want.now_time,
                                     result.step, result.skipped, result.now_time);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    ftsr_pkg::CFG_MODE:
                        mode_reg  = cfg_data[ftsr_pkg::MODE_BITS-1:0];
                    ftsr_pkg::CFG_CONST_STEP:   const_us  = longint'(cfg_data);
                    ftsr_pkg::CFG_MAX_STEP:     max_us    = longint'(cfg_data);
                    ftsr_pkg::CFG_MIN_STEP:     min_us    = longint'(cfg_data);
                    ftsr_pkg::CFG_SLEW_STEP:    slew_us   = longint'(cfg_data);
                    ftsr_pkg::CFG_MAX_SMOOTHED: smooth_us = longint'(cfg_data);
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                step_words.push_back(grant_step(item.kind, item.time_value, item.paused));
            fail_count <= errs;
            pending    <= step_words.size();
            held_time  <= now_us;
        end
    end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// bench for the frame time step regulator: a short directed walk through the
// modes and corner cases, then phases of random frame words under different
// register settings, with random stalls on both channels; the step checker
// beside the block does the prediction and comparison
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     PHASES      = 12;
    localparam int     PHASE_WORDS = 110;
    localparam int     REG_TOP     = 2_000_000;
    localparam longint TIME_TOP    = (longint'(1) << ftsr_pkg::TIME_BITS_DEF) - 1;

    // mode codes the block leaves unused, and a register index past the last one
    localparam logic [ftsr_pkg::MODE_BITS-1:0]    MODE_UNUSED_LO = 3'd6;
    localparam logic [ftsr_pkg::MODE_BITS-1:0]    MODE_UNUSED_HI = 3'd7;
    localparam logic [ftsr_pkg::CFG_IDX_BITS-1:0] CFG_PAST_END   = 3'd7;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we;
    logic [ftsr_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [ftsr_pkg::REG_BITS-1:0]     cfg_data;

    int     fail_count;
    int     pending;
    longint held_time;
    int     cycle_count;

    // calm stretches turn off all idling on both sides
    bit     calm;
    // rough wall clock used to build absolute frame times
    longint wall;
    // bench copy of the registers that shape the frame intervals
    int     cur_const, cur_max, cur_min;

    ftsr_in_if  item_ch ();
    ftsr_out_if res_ch ();

    frame_time_step_regulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ftsr_step_checker step_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (res_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .held_time  (held_time)
    );

    always #4 clk = ~clk;

    // idle lengths: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        if (r < 88)
            return int'($urandom_range(1, 3));
        if (r < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // frame interval, scaled to the programmed constant step
    function automatic longint pick_interval();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return longint'($urandom_range(0, 2 * cur_const));
        if (r < 90)
            return longint'($urandom_range(0, 4 * cur_const + cur_min));
        if (r < 98)
            return longint'($urandom_range(0, 2 * cur_max));
        return longint'($urandom_range(0, 20_000_000));
    endfunction

    // register value: extremes now and then, often around the reset value
    function automatic int pick_reg(int lo, int typical);
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 12)
            return lo;
        if (r < 22)
            return REG_TOP;
        if (r < 70)
            return int'($urandom_range(typical / 2, 2 * typical));
        return int'($urandom_range(lo, REG_TOP));
    endfunction

    // drive one frame word at the falling edge and hold it until accepted
    task automatic send_word(logic kind, logic [ftsr_pkg::TV_BITS-1:0] tv, logic paused);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= kind;
        item_ch.time_value <= tv;
        item_ch.paused     <= paused;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // stop sending and wait until every step word has come back
    task automatic drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(logic [ftsr_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [ftsr_pkg::REG_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // full register set; the mode word carries random upper bits that must be dropped
    task automatic configure(logic [ftsr_pkg::MODE_BITS-1:0] mode, int cs, int mx, int mn,
                             int sl, int sm);
        logic [ftsr_pkg::REG_BITS-1:0] mode_word;
        mode_word = ftsr_pkg::REG_BITS'($urandom());
        mode_word[ftsr_pkg::MODE_BITS-1:0] = mode;
        put_reg(ftsr_pkg::CFG_MODE, mode_word);
        put_reg(ftsr_pkg::CFG_CONST_STEP, ftsr_pkg::REG_BITS'(cs));
        put_reg(ftsr_pkg::CFG_MAX_STEP, ftsr_pkg::REG_BITS'(mx));
        put_reg(ftsr_pkg::CFG_MIN_STEP, ftsr_pkg::REG_BITS'(mn));
        put_reg(ftsr_pkg::CFG_SLEW_STEP, ftsr_pkg::REG_BITS'(sl));
        put_reg(ftsr_pkg::CFG_MAX_SMOOTHED, ftsr_pkg::REG_BITS'(sm));
        end_writes();
        cur_const = cs;
        cur_max   = mx;
        cur_min   = mn;
    endtask

    // directed: switch mode only, then one larger and one small delta word
    task automatic walk_mode(logic [ftsr_pkg::MODE_BITS-1:0] mode);
        drain();
        put_reg(ftsr_pkg::CFG_MODE, ftsr_pkg::REG_BITS'(mode));
        end_writes();
        send_word(1'b1, ftsr_pkg::TV_BITS'(40000), 1'b0);
        send_word(1'b1, ftsr_pkg::TV_BITS'(5000), 1'b0);
    endtask

    // random frame word: mostly time moving forward, the rest paused noise,
    // stale or repeated times
    task automatic random_word();
        int                            r;
        longint                        dt;
        longint                        back;
        logic [ftsr_pkg::TV_BITS-1:0]  noise;
        r  = int'($urandom_range(0, 99));
        dt = pick_interval();
        noise[ftsr_pkg::TV_BITS-1:32] = (ftsr_pkg::TV_BITS-32)'($urandom() >> 16);
        noise[31:0]                   = $urandom();
        if (held_time > wall)
            wall = held_time;
        if (r < 50) begin
            wall += dt;
            send_word(1'b0, ftsr_pkg::TV_BITS'(wall), 1'b0);
        end
        else if (r < 70) begin
            send_word(1'b1, ftsr_pkg::TV_BITS'(dt), 1'b0);
        end
        else if (r < 80) begin
            // paused words never move the held time, so any value is safe here
            send_word(1'($urandom_range(0, 1)), noise, 1'b1);
        end
        else if (r < 88) begin
            back = longint'($urandom_range(0, 2 * cur_const));
            send_word(1'b0, ftsr_pkg::TV_BITS'((wall > back) ? wall - back : 0), 1'b0);
        end
        else if (r < 92) begin
            send_word(1'b0, ftsr_pkg::TV_BITS'(wall), 1'b0);
        end
        else if (r < 96) begin
            send_word(1'($urandom_range(0, 1)), ftsr_pkg::TV_BITS'(dt), 1'b1);
        end
        else begin
            send_word(1'b1, ftsr_pkg::TV_BITS'($urandom_range(0, cur_min)), 1'b0);
        end
    endtask

    // result side: ready drops for random stretches outside calm periods
    initial begin
        int hold;
        hold         = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                res_ch.ready <= 1'b0;
                hold--;
            end
            else begin
                res_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 30)
                    hold = pick_gap();
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [ftsr_pkg::MODE_BITS-1:0] phase_mode;
        cfg_we             = 1'b0;
        cfg_index          = ftsr_pkg::CFG_MODE;
        cfg_data           = '0;
        item_ch.valid      = 1'b0;
        item_ch.kind       = 1'b0;
        item_ch.time_value = '0;
        item_ch.paused     = 1'b0;
        calm      = 1'b0;
        wall      = 0;
        cur_const = int'(ftsr_pkg::CONST_STEP_RST);
        cur_max   = int'(ftsr_pkg::MAX_STEP_RST);
        cur_min   = int'(ftsr_pkg::MIN_STEP_RST);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, starting from the reset registers (constant mode)
        send_word(1'b0, ftsr_pkg::TV_BITS'(0), 1'b0);      // time equal to held time: stale
        send_word(1'b0, ftsr_pkg::TV_BITS'(10000), 1'b0);  // gap under the minimum: skip
        send_word(1'b0, ftsr_pkg::TV_BITS'(60000), 1'b0);  // constant step granted
        send_word(1'b1, ftsr_pkg::TV_BITS'(0), 1'b0);      // zero delta: stale
        send_word(1'b0, '1, 1'b1);                         // paused, all ones absolute
        send_word(1'b1, '1, 1'b1);                         // paused, all ones delta
        walk_mode(ftsr_pkg::MODE_NONE);
        walk_mode(ftsr_pkg::MODE_CONST_OR_ABOVE);
        walk_mode(ftsr_pkg::MODE_CONST_OR_BELOW);
        walk_mode(ftsr_pkg::MODE_BELOW);
        walk_mode(ftsr_pkg::MODE_CONSTANT);
        walk_mode(ftsr_pkg::MODE_FIRST_ORDER);
        walk_mode(MODE_UNUSED_LO);
        // a write past the last register must leave everything alone
        drain();
        put_reg(CFG_PAST_END, '1);
        end_writes();
        walk_mode(MODE_UNUSED_HI);

        // random phases, each under its own register set
        for (int p = 0; p < PHASES; p++) begin
            drain();
            phase_mode = (p < 6) ? ftsr_pkg::MODE_BITS'(p)
                                 : ftsr_pkg::MODE_BITS'($urandom_range(0, 5));
            if (p == 0)
                configure(phase_mode, int'(ftsr_pkg::CONST_STEP_RST),
                          int'(ftsr_pkg::MAX_STEP_RST), int'(ftsr_pkg::MIN_STEP_RST),
                          int'(ftsr_pkg::SLEW_STEP_RST), int'(ftsr_pkg::MAX_SMOOTHED_RST));
            else if (p == 6)
                configure(phase_mode, 1, 1, 0, 0, 1);
            else if (p == 7)
                configure(phase_mode, REG_TOP, REG_TOP, REG_TOP, REG_TOP, REG_TOP);
            else
                configure(phase_mode, pick_reg(1, 33333), pick_reg(1, 990000),
                          pick_reg(0, 16667), pick_reg(0, 6667), pick_reg(1, 100000));
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (i % 30 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // hold off the sender mid-phase until the block runs dry
                if (p == 3 && i == PHASE_WORDS / 2)
                    drain();
                random_word();
            end
        end
        calm = 1'b0;

        // time saturation at the end of the run, since it pins the held time
        drain();
        configure(ftsr_pkg::MODE_FIRST_ORDER, 33333, 990000, 16667, 6667, 1000);
        // huge step saturates to int32
        send_word(1'b0, ftsr_pkg::TV_BITS'(TIME_TOP - 1), 1'b0);
        drain();
        configure(ftsr_pkg::MODE_NONE, 33333, 990000, 16667, 6667, 100000);
        send_word(1'b0, ftsr_pkg::TV_BITS'(TIME_TOP), 1'b0);
        send_word(1'b1, '1, 1'b0);                       // delta sum saturates: stale
        send_word(1'b0, '1, 1'b0);
        send_word(1'b1, '1, 1'b1);
        drain();
        configure(ftsr_pkg::MODE_CONST_OR_BELOW, REG_TOP, 1, 0, REG_TOP, REG_TOP);
        send_word(1'b0, '1, 1'b1);
        send_word(1'b1, ftsr_pkg::TV_BITS'(12345), 1'b1);
        drain();
        configure(ftsr_pkg::MODE_BELOW, REG_TOP, REG_TOP, 0, 0, 1);
        send_word(1'b0, ftsr_pkg::TV_BITS'(0), 1'b1);
        send_word(1'b1, '1, 1'b1);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
